### rtl/cpc_pkg.sv
// Shared types and constants for the class probability colorizer.
`default_nettype none

package cpc_pkg;

   localparam int NUM_INPUTS   = 8;
   localparam int MAX_CHANNELS = 8;
   localparam int CH_IDX_W     = $clog2(NUM_INPUTS);
   localparam int CH_COUNT_W   = 4;
   localparam int PROB_W       = 16;
   localparam int COMP_W       = 8;
   localparam int NUM_COMP     = 3;
   localparam int COLOR_W      = COMP_W * NUM_COMP;
   localparam int CLASS_W      = 8;
   localparam int MODE_W       = 3;
   localparam int CSR_INDEX_W  = 4;
   localparam int CSR_DATA_W   = 64;

   localparam logic [COMP_W-1:0] GREY_INVALID = COMP_W'(127);

   // Register indexes on the configuration channel.
   localparam logic [CSR_INDEX_W-1:0] REG_CHANNEL_COUNT = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_CLASS_IDS     = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] REG_PALETTE_01    = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] REG_PALETTE_23    = CSR_INDEX_W'(3);
   localparam logic [CSR_INDEX_W-1:0] REG_PALETTE_45    = CSR_INDEX_W'(4);
   localparam logic [CSR_INDEX_W-1:0] REG_PALETTE_67    = CSR_INDEX_W'(5);
   localparam logic [CSR_INDEX_W-1:0] REG_THRESHOLD     = CSR_INDEX_W'(6);
   localparam logic [CSR_INDEX_W-1:0] REG_OUTPUT_MODE   = CSR_INDEX_W'(7);

   // Output modes.
   localparam logic [MODE_W-1:0] MODE_ID_ONLY   = MODE_W'(0);
   localparam logic [MODE_W-1:0] MODE_THRESH    = MODE_W'(1);
   localparam logic [MODE_W-1:0] MODE_RAW       = MODE_W'(2);
   localparam logic [MODE_W-1:0] MODE_MEAN      = MODE_W'(3);
   localparam logic [MODE_W-1:0] MODE_BLEND     = MODE_W'(4);

   typedef struct packed {
      logic [CH_COUNT_W-1:0]                channel_count;
      logic [NUM_INPUTS-1:0][CLASS_W-1:0]   class_ids;
      logic [NUM_INPUTS-1:0][COLOR_W-1:0]   palette;
      logic [PROB_W-1:0]                    threshold;
      logic [MODE_W-1:0]                    output_mode;
   } cfg_type;

endpackage

`default_nettype wire

### rtl/cpc_csr.sv
// Configuration register file of the class probability colorizer.
`default_nettype none

module cpc_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire logic [cpc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [cpc_pkg::CSR_DATA_W-1:0]    csr_data,
   output      cpc_pkg::cfg_type                  cfg
);

   cpc_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_count <= cpc_pkg::CH_COUNT_W'(8);
         for (int k = 0; k < cpc_pkg::NUM_INPUTS; k++) begin
            cfg_ff.class_ids[k] <= cpc_pkg::CLASS_W'(k);
            cfg_ff.palette[k]   <= '0;
         end
         cfg_ff.threshold   <= cpc_pkg::PROB_W'(19661);
         cfg_ff.output_mode <= cpc_pkg::MODE_BLEND;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cpc_pkg::REG_CHANNEL_COUNT: begin
               cfg_ff.channel_count <= csr_data[cpc_pkg::CH_COUNT_W-1:0];
            end
            cpc_pkg::REG_CLASS_IDS: begin
               cfg_ff.class_ids <= csr_data[cpc_pkg::NUM_INPUTS*cpc_pkg::CLASS_W-1:0];
            end
            cpc_pkg::REG_PALETTE_01: begin
               cfg_ff.palette[0] <= csr_data[cpc_pkg::COLOR_W-1:0];
               cfg_ff.palette[1] <= csr_data[2*cpc_pkg::COLOR_W-1:cpc_pkg::COLOR_W];
            end
            cpc_pkg::REG_PALETTE_23: begin
               cfg_ff.palette[2] <= csr_data[cpc_pkg::COLOR_W-1:0];
               cfg_ff.palette[3] <= csr_data[2*cpc_pkg::COLOR_W-1:cpc_pkg::COLOR_W];
            end
            cpc_pkg::REG_PALETTE_45: begin
               cfg_ff.palette[4] <= csr_data[cpc_pkg::COLOR_W-1:0];
               cfg_ff.palette[5] <= csr_data[2*cpc_pkg::COLOR_W-1:cpc_pkg::COLOR_W];
            end
            cpc_pkg::REG_PALETTE_67: begin
               cfg_ff.palette[6] <= csr_data[cpc_pkg::COLOR_W-1:0];
               cfg_ff.palette[7] <= csr_data[2*cpc_pkg::COLOR_W-1:cpc_pkg::COLOR_W];
            end
            cpc_pkg::REG_THRESHOLD: begin
               cfg_ff.threshold <= csr_data[cpc_pkg::PROB_W-1:0];
            end
            cpc_pkg::REG_OUTPUT_MODE: begin
               cfg_ff.output_mode <= csr_data[cpc_pkg::MODE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

### rtl/class_probability_colorizer_top.sv
// Top level of the class probability colorizer: arg-max, threshold and color pipeline.
//
// Usage:
//   Pixels enter on the request channel: a transaction happens at each rising edge
//   with start high and busy low. busy is always low, so a pixel may be offered in
//   every cycle; the block sustains one pixel per clock.
//   Each pixel yields exactly one result. rsp_valid rises once the pixel has passed
//   all four register ranks and is high for a single cycle per result; a result is
//   taken at each rising edge with rsp_valid high. Results come out in request order.
//   The pipeline has four register ranks: input capture, products and first
//   arg-max level, channel sums and final winner, and the output register. Each
//   rank moves forward every cycle; the receiver cannot stall it.
//   Configuration registers are written on the csr_ channel (csr_ready is always
//   high) and should only change while no pixel is in flight.
//   Synchronous reset clears all valid bits and returns the registers to their
//   defaults; pixels in flight at reset are dropped.
`default_nettype none

module class_probability_colorizer_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output      logic                              busy,
   input  wire logic [cpc_pkg::PROB_W-1:0]        req_prob_0,
   input  wire logic [cpc_pkg::PROB_W-1:0]        req_prob_1,
   input  wire logic [cpc_pkg::PROB_W-1:0]        req_prob_2,
   input  wire logic [cpc_pkg::PROB_W-1:0]        req_prob_3,
   input  wire logic [cpc_pkg::PROB_W-1:0]        req_prob_4,
   input  wire logic [cpc_pkg::PROB_W-1:0]        req_prob_5,
   input  wire logic [cpc_pkg::PROB_W-1:0]        req_prob_6,
   input  wire logic [cpc_pkg::PROB_W-1:0]        req_prob_7,
   output      logic                              rsp_valid,
   output      logic [cpc_pkg::CLASS_W-1:0]       rsp_class_id,
   output      logic                              rsp_valid_res,
   output      logic [cpc_pkg::COMP_W-1:0]        rsp_blue,
   output      logic [cpc_pkg::COMP_W-1:0]        rsp_green,
   output      logic [cpc_pkg::COMP_W-1:0]        rsp_red,
   input  wire logic                              csr_valid,
   output      logic                              csr_ready,
   input  wire logic [cpc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [cpc_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int NIN  = cpc_pkg::NUM_INPUTS;
   localparam int NODE = NIN / 2;
   localparam int PW   = cpc_pkg::PROB_W;
   localparam int CW   = cpc_pkg::COMP_W;
   localparam int IW   = cpc_pkg::CH_IDX_W;
   localparam int NC   = cpc_pkg::NUM_COMP;
   localparam int SUMW = CW + IW;

   // Rounds a Q1.15 product half to even and saturates it to one color component.
   function automatic logic [CW-1:0] round_sat(input logic [PW+CW-1:0] x);
      logic [CW+1:0] q;
      q = (CW+2)'(x[PW+CW-1:15]);
      if (x[14:0] > 15'h4000 || (x[14:0] == 15'h4000 && x[15])) begin
         q = q + (CW+2)'(1);
      end
      return (q > (CW+2)'(255)) ? CW'(255) : q[CW-1:0];
   endfunction

   cpc_pkg::cfg_type cfg;

   cpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   assign busy = 1'b0;

   logic accept;
   assign accept = start && !busy;

   // Effective channel count and per-channel enables.
   logic [cpc_pkg::CH_COUNT_W-1:0] n_eff;
   logic [NIN-1:0]                 chan_en;

   always_comb begin
      if (cfg.channel_count == '0) begin
         n_eff = cpc_pkg::CH_COUNT_W'(1);
      end else if (cfg.channel_count > cpc_pkg::CH_COUNT_W'(cpc_pkg::MAX_CHANNELS)) begin
         n_eff = cpc_pkg::CH_COUNT_W'(cpc_pkg::MAX_CHANNELS);
      end else begin
         n_eff = cfg.channel_count;
      end
      for (int k = 0; k < NIN; k++) begin
         chan_en[k] = cpc_pkg::CH_COUNT_W'(k) < n_eff;
      end
   end

   // Rank 0: input capture.
   logic                   s0_valid_ff;
   logic [NIN-1:0][PW-1:0] s0_prob_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s0_prob_ff <= {req_prob_7, req_prob_6, req_prob_5, req_prob_4,
                        req_prob_3, req_prob_2, req_prob_1, req_prob_0};
      end
   end

   // Rank 1: rounded products per channel and component, first arg-max level.
   logic [NIN-1:0][NC-1:0][CW-1:0] s1_term_in;
   logic [NODE-1:0][PW-1:0]        s1_node_p_in;
   logic [NODE-1:0][IW-1:0]        s1_node_idx_in;
   logic [NODE-1:0]                s1_node_en_in;

   always_comb begin
      for (int k = 0; k < NIN; k++) begin
         for (int c = 0; c < NC; c++) begin
            s1_term_in[k][c] = chan_en[k]
               ? round_sat(s0_prob_ff[k] * cfg.palette[k][c*CW +: CW]) : '0;
         end
      end
      // Ties go to the later channel; channels in use are contiguous from zero.
      for (int j = 0; j < NODE; j++) begin
         if (chan_en[2*j+1] && s0_prob_ff[2*j+1] >= s0_prob_ff[2*j]) begin
            s1_node_p_in[j]   = s0_prob_ff[2*j+1];
            s1_node_idx_in[j] = IW'(2*j+1);
         end else begin
            s1_node_p_in[j]   = s0_prob_ff[2*j];
            s1_node_idx_in[j] = IW'(2*j);
         end
         s1_node_en_in[j] = chan_en[2*j];
      end
   end

   logic                           s1_valid_ff;
   logic [NIN-1:0][NC-1:0][CW-1:0] s1_term_ff;
   logic [NODE-1:0][PW-1:0]        s1_node_p_ff;
   logic [NODE-1:0][IW-1:0]        s1_node_idx_ff;
   logic [NODE-1:0]                s1_node_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_term_ff     <= s1_term_in;
      s1_node_p_ff   <= s1_node_p_in;
      s1_node_idx_ff <= s1_node_idx_in;
      s1_node_en_ff  <= s1_node_en_in;
   end

   // Rank 2: saturating channel sums and the final winner.
   logic [PW-1:0]          l2_p   [2];
   logic [IW-1:0]          l2_idx [2];
   logic                   l2_en  [2];
   logic [PW-1:0]          s2_maxp_in;
   logic [IW-1:0]          s2_win_in;
   logic [NC-1:0][CW-1:0]  s2_mean_in;
   logic [SUMW-1:0]        sum_acc;

   always_comb begin
      for (int j = 0; j < 2; j++) begin
         if (s1_node_en_ff[2*j+1] && s1_node_p_ff[2*j+1] >= s1_node_p_ff[2*j]) begin
            l2_p[j]   = s1_node_p_ff[2*j+1];
            l2_idx[j] = s1_node_idx_ff[2*j+1];
         end else begin
            l2_p[j]   = s1_node_p_ff[2*j];
            l2_idx[j] = s1_node_idx_ff[2*j];
         end
         l2_en[j] = s1_node_en_ff[2*j];
      end
      if (l2_en[1] && l2_p[1] >= l2_p[0]) begin
         s2_maxp_in = l2_p[1];
         s2_win_in  = l2_idx[1];
      end else begin
         s2_maxp_in = l2_p[0];
         s2_win_in  = l2_idx[0];
      end
      // All terms are non-negative, so clamping the plain sum equals a running
      // sum that saturates at each step.
      for (int c = 0; c < NC; c++) begin
         sum_acc = '0;
         for (int k = 0; k < NIN; k++) begin
            sum_acc = sum_acc + SUMW'(s1_term_ff[k][c]);
         end
         s2_mean_in[c] = (sum_acc > SUMW'(255)) ? CW'(255) : sum_acc[CW-1:0];
      end
   end

   logic                  s2_valid_ff;
   logic [PW-1:0]         s2_maxp_ff;
   logic [IW-1:0]         s2_win_ff;
   logic [NC-1:0][CW-1:0] s2_mean_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_maxp_ff <= s2_maxp_in;
      s2_win_ff  <= s2_win_in;
      s2_mean_ff <= s2_mean_in;
   end

   // Rank 3: threshold, favorite color, mode selection and blend.
   logic                            valid_res_in;
   logic [cpc_pkg::COLOR_W-1:0]     fav;
   logic [CW-1:0]                   fav_c;
   logic [CW-1:0]                   favt_c;
   logic [CW:0]                     blend_s;
   logic [CW-1:0]                   blend_q;
   logic [NC-1:0][CW-1:0]           res_in;

   always_comb begin
      valid_res_in = s2_maxp_ff >= cfg.threshold;
      fav          = cfg.palette[s2_win_ff];
      for (int c = 0; c < NC; c++) begin
         fav_c   = fav[c*CW +: CW];
         favt_c  = valid_res_in ? fav_c : cpc_pkg::GREY_INVALID;
         blend_s = (CW+1)'(s2_mean_ff[c]) + (CW+1)'(favt_c);
         blend_q = blend_s[CW:1];
         if (blend_s[0] && blend_q[0]) begin
            blend_q = blend_q + CW'(1);
         end
         case (cfg.output_mode)
            cpc_pkg::MODE_THRESH: res_in[c] = favt_c;
            cpc_pkg::MODE_RAW:    res_in[c] = fav_c;
            cpc_pkg::MODE_MEAN:   res_in[c] = s2_mean_ff[c];
            cpc_pkg::MODE_BLEND:  res_in[c] = blend_q;
            default:              res_in[c] = '0;
         endcase
      end
   end

   logic                  rsp_valid_ff;
   logic [CW-1:0]         rsp_class_id_ff;
   logic                  rsp_valid_res_ff;
   logic [NC-1:0][CW-1:0] rsp_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_class_id_ff  <= cfg.class_ids[s2_win_ff];
      rsp_valid_res_ff <= valid_res_in;
      rsp_color_ff     <= res_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_class_id  = rsp_class_id_ff;
   assign rsp_valid_res = rsp_valid_res_ff;
   assign rsp_blue      = rsp_color_ff[0];
   assign rsp_green     = rsp_color_ff[1];
   assign rsp_red       = rsp_color_ff[2];

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##4 rsp_valid)
      else $error("accepted pixel did not produce a result four cycles later");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 4))
      else $error("result strobe without a matching request");

   a_mode_id_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(cfg.output_mode) == cpc_pkg::MODE_ID_ONLY
      |-> rsp_blue == '0 && rsp_green == '0 && rsp_red == '0)
      else $error("color not zero in id-only mode");

   a_grey_invalid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res && $past(cfg.output_mode) == cpc_pkg::MODE_THRESH
      |-> rsp_blue == cpc_pkg::GREY_INVALID && rsp_green == cpc_pkg::GREY_INVALID
          && rsp_red == cpc_pkg::GREY_INVALID)
      else $error("invalid pixel not grey in thresholded mode");
`endif

endmodule

`default_nettype wire

### verif/tb.sv
// Self-checking testbench for the class probability colorizer: directed and random pixels.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cpc_pkg::*;

   localparam int unsigned PROB_ONE     = 32768;
   localparam int unsigned COMP_MAX     = 255;
   localparam int unsigned PIPE_LATENCY = 4;

   typedef logic [NUM_INPUTS-1:0][PROB_W-1:0] prob_vec_type;

   typedef struct packed {
      logic [CLASS_W-1:0] class_id;
      logic               valid_res;
      logic [COMP_W-1:0]  blue;
      logic [COMP_W-1:0]  green;
      logic [COMP_W-1:0]  red;
   } pixel_result_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   prob_vec_type           req_probs;
   logic                   rsp_valid;
   logic [CLASS_W-1:0]     rsp_class_id;
   logic                   rsp_valid_res;
   logic [COMP_W-1:0]      rsp_blue;
   logic [COMP_W-1:0]      rsp_green;
   logic [COMP_W-1:0]      rsp_red;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   cfg_type          cfg_model;
   pixel_result_type expected_pixels[$];
   int unsigned      mismatch_count = 0;

   class_probability_colorizer_top dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_prob_0    (req_probs[0]),
      .req_prob_1    (req_probs[1]),
      .req_prob_2    (req_probs[2]),
      .req_prob_3    (req_probs[3]),
      .req_prob_4    (req_probs[4]),
      .req_prob_5    (req_probs[5]),
      .req_prob_6    (req_probs[6]),
      .req_prob_7    (req_probs[7]),
      .rsp_valid     (rsp_valid),
      .rsp_class_id  (rsp_class_id),
      .rsp_valid_res (rsp_valid_res),
      .rsp_blue      (rsp_blue),
      .rsp_green     (rsp_green),
      .rsp_red       (rsp_red),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Arg-max, threshold and color rules applied to one pixel under cfg_model.
   function automatic pixel_result_type predict_pixel(prob_vec_type p);
      int unsigned       n, win, maxp, prod, q, sum, s;
      logic [COMP_W-1:0] fav [NUM_COMP];
      logic [COMP_W-1:0] favc [NUM_COMP];
      logic [COMP_W-1:0] mean [NUM_COMP];
      logic [COMP_W-1:0] comp [NUM_COMP];
      logic              valid;
      pixel_result_type  r;
      n = 32'(cfg_model.channel_count);
      if (n < 1) n = 1;
      if (n > MAX_CHANNELS) n = MAX_CHANNELS;
      win  = 0;
      maxp = 0;
      // Greater-or-equal lets the later channel win a tie.
      for (int k = 0; k < n; k++) begin
         if (p[k] >= maxp) begin
            maxp = 32'(p[k]);
            win  = k;
         end
      end
      valid = (maxp >= cfg_model.threshold);
      for (int c = 0; c < NUM_COMP; c++) begin
         fav[c]  = cfg_model.palette[win][c*COMP_W +: COMP_W];
         favc[c] = valid ? fav[c] : GREY_INVALID;
         sum = 0;
         for (int k = 0; k < n; k++) begin
            prod = p[k] * cfg_model.palette[k][c*COMP_W +: COMP_W];
            q = prod >> 15;
            if ((prod & 32'h7FFF) > 32'h4000 || ((prod & 32'h7FFF) == 32'h4000 && (q & 1)))
               q++;
            if (q > COMP_MAX) q = COMP_MAX;
            sum += q;
            if (sum > COMP_MAX) sum = COMP_MAX;
         end
         mean[c] = COMP_W'(sum);
         s = mean[c] + favc[c];
         q = s >> 1;
         if ((s & 1) && (q & 1)) q++;
         case (cfg_model.output_mode)
            MODE_THRESH: comp[c] = favc[c];
            MODE_RAW:    comp[c] = fav[c];
            MODE_MEAN:   comp[c] = mean[c];
            MODE_BLEND:  comp[c] = COMP_W'(q);
            default:     comp[c] = '0;
         endcase
      end
      r.class_id  = cfg_model.class_ids[win];
      r.valid_res = valid;
      r.blue      = comp[0];
      r.green     = comp[1];
      r.red       = comp[2];
      return r;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] noise_word();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [COLOR_W-1:0] random_color();
      logic [COLOR_W-1:0] c;
      for (int i = 0; i < NUM_COMP; i++) begin
         case ($urandom_range(0, 3))
            0:       c[i*COMP_W +: COMP_W] = '0;
            1:       c[i*COMP_W +: COMP_W] = '1;
            default: c[i*COMP_W +: COMP_W] = COMP_W'($urandom);
         endcase
      end
      return c;
   endfunction

   function automatic prob_vec_type random_pixel();
      prob_vec_type p;
      int unsigned  style, base, lead;
      int           near;
      style = $urandom_range(0, 9);
      base  = $urandom_range(0, PROB_ONE);
      lead  = $urandom_range(0, NUM_INPUTS - 1);
      for (int k = 0; k < NUM_INPUTS; k++) begin
         near = int'(cfg_model.threshold) + int'($urandom_range(0, 4)) - 2;
         case (style)
            5: p[k] = (k == lead) ? PROB_W'($urandom_range(PROB_ONE / 2, PROB_ONE))
                                  : PROB_W'($urandom_range(0, PROB_ONE / 2));
            6: p[k] = PROB_W'($urandom);
            // Many equal values so that ties between channels are common.
            7: p[k] = $urandom_range(0, 1) ? PROB_W'(base) : PROB_W'($urandom_range(0, base));
            8: begin
               case ($urandom_range(0, 4))
                  0:       p[k] = '0;
                  1:       p[k] = PROB_W'(1);
                  2:       p[k] = PROB_W'(PROB_ONE - 1);
                  3:       p[k] = PROB_W'(PROB_ONE);
                  default: p[k] = '1;
               endcase
            end
            9: p[k] = (near < 0) ? '0 : (near > 16'hFFFF) ? '1 : PROB_W'(near);
            default: p[k] = PROB_W'($urandom_range(0, PROB_ONE));
         endcase
      end
      return p;
   endfunction

   task automatic send_pixel(input prob_vec_type p);
      pixel_result_type predicted;
      start     <= 1'b1;
      req_probs <= p;
      do @(posedge clock); while (busy);
      predicted       = predict_pixel(p);
      expected_pixels = {expected_pixels, predicted};
   endtask

   task automatic pause_sender(input int unsigned cycles);
      start     <= 1'b0;
      req_probs <= random_pixel();
      repeat (cycles) @(posedge clock);
   endtask

   // Holds the sender off until every pixel in flight has produced its result.
   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (expected_pixels.size() != 0);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_CHANNEL_COUNT: cfg_model.channel_count = data[CH_COUNT_W-1:0];
         REG_CLASS_IDS:     cfg_model.class_ids     = data;
         REG_PALETTE_01:    cfg_model.palette[1:0]  = data[2*COLOR_W-1:0];
         REG_PALETTE_23:    cfg_model.palette[3:2]  = data[2*COLOR_W-1:0];
         REG_PALETTE_45:    cfg_model.palette[5:4]  = data[2*COLOR_W-1:0];
         REG_PALETTE_67:    cfg_model.palette[7:6]  = data[2*COLOR_W-1:0];
         REG_THRESHOLD:     cfg_model.threshold     = data[PROB_W-1:0];
         REG_OUTPUT_MODE:   cfg_model.output_mode   = data[MODE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic reconfigure(input logic [CSR_INDEX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] data);
      drain_results();
      csr_write(idx, data);
   endtask

   // Writes every register with random contents; upper bits carry noise to test masking.
   task automatic random_config();
      logic [CSR_DATA_W-1:0] d;
      drain_results();
      csr_write(REG_CHANNEL_COUNT, noise_word());
      csr_write(REG_CLASS_IDS, noise_word());
      d = noise_word();
      d[2*COLOR_W-1:0] = {random_color(), random_color()};
      csr_write(REG_PALETTE_01, d);
      d[2*COLOR_W-1:0] = {random_color(), random_color()};
      csr_write(REG_PALETTE_23, d);
      d[2*COLOR_W-1:0] = {random_color(), random_color()};
      csr_write(REG_PALETTE_45, d);
      d[2*COLOR_W-1:0] = {random_color(), random_color()};
      csr_write(REG_PALETTE_67, d);
      d = noise_word();
      case ($urandom_range(0, 4))
         0:       d[PROB_W-1:0] = '0;
         1:       d[PROB_W-1:0] = PROB_W'(PROB_ONE);
         2:       d[PROB_W-1:0] = '1;
         default: d[PROB_W-1:0] = PROB_W'($urandom_range(0, PROB_ONE));
      endcase
      csr_write(REG_THRESHOLD, d);
      csr_write(REG_OUTPUT_MODE, noise_word());
      csr_write(CSR_INDEX_W'($urandom_range(REG_OUTPUT_MODE + 1, (1 << CSR_INDEX_W) - 1)),
                noise_word());
   endtask

   // Random pixels in bursts; a burst ends in a gap or, now and then, a full drain.
   task automatic send_stream(input int unsigned count);
      int unsigned burst;
      burst = 0;
      for (int unsigned i = 0; i < count; i++) begin
         if (burst == 0) begin
            burst = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 12);
            if (i != 0) begin
               if ($urandom_range(0, 9) == 0) drain_results();
               else pause_sender($urandom_range(1, 6));
            end
         end
         send_pixel(random_pixel());
         burst--;
      end
   endtask

   task automatic test_reset_defaults();
      for (int i = 0; i < 10; i++) send_pixel(random_pixel());
   endtask

   task automatic test_directed();
      prob_vec_type p;
      reconfigure(REG_CLASS_IDS, 64'hF0E1_D2C3_B4A5_9687);
      reconfigure(REG_PALETTE_01, {24'hFF0301, 24'hFFFFFF});
      reconfigure(REG_PALETTE_23, {24'h808080, 24'h010203});
      reconfigure(REG_PALETTE_45, {24'h00FF00, 24'hFF0000});
      reconfigure(REG_PALETTE_67, {24'h0000FF, 24'h7F7F7F});
      // All channels equal: the last channel takes the tie.
      send_pixel('0);
      send_pixel({NUM_INPUTS{PROB_W'(PROB_ONE)}});
      // Probabilities near two saturate every product with a palette component of 128 or more.
      send_pixel('1);
      for (int k = 0; k < NUM_INPUTS; k++) begin
         p = '0;
         p[k] = PROB_W'(PROB_ONE);
         send_pixel(p);
      end
      p = '0;
      p[2] = PROB_W'(20000);
      p[5] = PROB_W'(20000);
      p[7] = PROB_W'(19999);
      send_pixel(p);
      p = '0;
      p[3] = cfg_model.threshold;
      send_pixel(p);
      p[3] = cfg_model.threshold - 1;
      send_pixel(p);
      // Half a unit lands exactly on the rounding boundary with odd palette components.
      send_pixel({NUM_INPUTS{PROB_W'(PROB_ONE / 2)}});
      reconfigure(REG_OUTPUT_MODE, MODE_RAW);
      send_pixel({NUM_INPUTS{PROB_W'(100)}});
      reconfigure(REG_OUTPUT_MODE, MODE_THRESH);
      send_pixel({NUM_INPUTS{PROB_W'(100)}});
      reconfigure(REG_THRESHOLD, '0);
      send_pixel('0);
      reconfigure(REG_THRESHOLD, CSR_DATA_W'(16'hFFFF));
      send_pixel('1);
      reconfigure(REG_OUTPUT_MODE, MODE_ID_ONLY);
      send_pixel({NUM_INPUTS{PROB_W'(PROB_ONE)}});
      reconfigure(REG_OUTPUT_MODE, MODE_MEAN);
      send_pixel({NUM_INPUTS{PROB_W'(PROB_ONE)}});
      reconfigure(REG_OUTPUT_MODE, CSR_DATA_W'(MODE_BLEND + 1));
      send_pixel({NUM_INPUTS{PROB_W'(PROB_ONE)}});
      reconfigure(REG_OUTPUT_MODE, MODE_BLEND);
      // A zero channel count acts as one channel, so channel 1 is ignored.
      reconfigure(REG_CHANNEL_COUNT, '0);
      p = '0;
      p[0] = PROB_W'(10);
      p[1] = PROB_W'(30000);
      send_pixel(p);
      reconfigure(REG_CHANNEL_COUNT, CSR_DATA_W'((1 << CH_COUNT_W) - 1));
      send_pixel(random_pixel());
   endtask

   task automatic test_output_modes();
      for (int m = 0; m < (1 << MODE_W); m++) begin
         random_config();
         csr_write(REG_OUTPUT_MODE, CSR_DATA_W'(m));
         send_stream(30);
      end
   endtask

   task automatic test_channel_counts();
      random_config();
      for (int n = 0; n < (1 << CH_COUNT_W); n++) begin
         reconfigure(REG_CHANNEL_COUNT, CSR_DATA_W'(n));
         send_stream(20);
      end
   endtask

   task automatic test_random_configs();
      for (int i = 0; i < 10; i++) begin
         random_config();
         send_stream(80);
      end
   endtask

   function automatic void check_field(input string name, input logic [COMP_W-1:0] want,
                                       input logic [COMP_W-1:0] got);
      if (got !== want) begin
         $display("time %0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Each result transaction is compared with the oldest predicted pixel.
   always @(posedge clock) begin
      pixel_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_pixels.size() == 0) begin
            $display("time %0t: unexpected result, expected none, actual class_id %0d",
                     $time, rsp_class_id);
            mismatch_count++;
         end else begin
            want = expected_pixels.pop_front();
            check_field("class_id", want.class_id, rsp_class_id);
            check_field("valid_res", COMP_W'(want.valid_res), COMP_W'(rsp_valid_res));
            check_field("blue", want.blue, rsp_blue);
            check_field("green", want.green, rsp_green);
            check_field("red", want.red, rsp_red);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      reset     <= 1'b1;
      start     <= 1'b0;
      req_probs <= '0;
      csr_valid <= 1'b0;
      csr_index <= REG_CHANNEL_COUNT;
      csr_data  <= '0;
      cfg_model.channel_count = CH_COUNT_W'(MAX_CHANNELS);
      cfg_model.class_ids     = 64'h0706_0504_0302_0100;
      cfg_model.palette       = '0;
      cfg_model.threshold     = PROB_W'(19661);
      cfg_model.output_mode   = MODE_BLEND;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed();
      test_output_modes();
      test_channel_counts();
      test_random_configs();
      drain_results();
      repeat (2 * PIPE_LATENCY) @(posedge clock);
      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

### class_probability_colorizer_top.f
rtl/cpc_pkg.sv
rtl/cpc_csr.sv
rtl/class_probability_colorizer_top.sv
verif/tb.sv
